>>> src/thb_pkg.sv
// Shared types, constants and tables for the track heading block.
// Used by the CORDIC unit and the top level; depends on nothing.
package thb_pkg;

    localparam int TEAM_W      = 6;
    localparam int ANGLE_W     = 32;
    localparam int HEAD_W      = 16;
    localparam int SRC_W       = 2;
    localparam int XY_W        = 36;
    localparam int Z_W         = 34;
    localparam int TEAMS_DEF   = 64;
    localparam int ITER_DEF    = 16;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    localparam logic [SRC_W-1:0] SRC_REPORTED = 2'd0;
    localparam logic [SRC_W-1:0] SRC_BEARING  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_NEW_TEAM = 2'd2;

    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic start;
        logic vector;
    } cu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cu_stat_t;

endpackage

>>> src/track_heading_with_bearing_fallback.sv
// Top level of the track heading block: sequencer, shared multiplier and team store.
// Depends on thb_pkg, thb_ram and thb_cordic.
//
// Input items arrive on the s_axis channel: team, latitude, longitude and a reported
// heading in tdata, the position and heading valid flags in tuser. An item without a
// valid position is taken and gives no result. Every other item gives one
// result on the m_axis channel: team, latitude, longitude and heading in tdata and the
// heading source in tuser.
// A reported heading or a new team goes from the store read and decision straight to the output.
// A computed bearing runs three CORDIC rotations on the single shared CORDIC unit, then
// the four multiplies and, unless both vectoring inputs are zero, one vectoring pass.
// One item is in work at a time; the next item can be taken in the cycle after the
// result is delivered. After reset the block clears the team store, one entry per cycle,
// with s_axis_tready low. A result waits in the output register while the receiver
// stalls, and no new item is taken until it is delivered.
module track_heading_with_bearing_fallback #(
    parameter int TEAMS             = thb_pkg::TEAMS_DEF,
    parameter int CORDIC_ITERATIONS = thb_pkg::ITER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // team[5:0], latitude[37:6], longitude[69:38], yaw_in[85:70], zero fill
    input  logic [87:0] s_axis_tdata,
    // position_valid[0], yaw_valid[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // team_out[5:0], latitude_out[37:6], longitude_out[69:38], heading[85:70], zero fill
    output logic [87:0] m_axis_tdata,
    // heading_source[1:0]
    output logic [1:0]  m_axis_tuser
);
    localparam int IW   = (TEAMS > 1) ? $clog2(TEAMS) : 1;
    localparam int AW   = thb_pkg::ANGLE_W;
    localparam int XYW  = thb_pkg::XY_W;
    localparam int ZW   = thb_pkg::Z_W;
    localparam int RW   = 2 * AW + 1;

    typedef enum logic [9:0] {
        ST_CLR  = 10'b0000000001,
        ST_IDLE = 10'b0000000010,
        ST_READ = 10'b0000000100,
        ST_DEC  = 10'b0000001000,
        ST_ROT  = 10'b0000010000,
        ST_ROTW = 10'b0000100000,
        ST_MUL  = 10'b0001000000,
        ST_VEC  = 10'b0010000000,
        ST_VECW = 10'b0100000000,
        ST_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0] idx_lut [64];
    for (genvar g = 0; g < 64; g++) begin : g_idx
        assign idx_lut[g] = IW'(g % TEAMS);
    end

    logic [IW-1:0]               clr_reg, clr_next;
    logic [thb_pkg::TEAM_W-1:0]  team_reg, team_next;
    logic [AW-1:0]               lat_reg, lat_next, lon_reg, lon_next;
    logic                        yawv_reg, yawv_next;
    logic [thb_pkg::HEAD_W-1:0]  yaw_reg, yaw_next, head_reg, head_next;
    logic [thb_pkg::SRC_W-1:0]   src_reg, src_next;
    logic [AW-1:0]               ang1_reg, ang1_next, dlon_reg, dlon_next;
    logic [1:0]                  sc_reg, sc_next;
    logic                        flip_reg, flip_next;
    logic [2:0]                  ms_reg, ms_next;
    logic signed [31:0]          s1_reg, s1_next, c1_reg, c1_next, s2_reg, s2_next;
    logic signed [31:0]          c2_reg, c2_next, sd_reg, sd_next, cd_reg, cd_next;
    logic signed [31:0]          t_reg, t_next;
    logic signed [ZW-1:0]        y_reg, y_next, p_reg, p_next;
    logic signed [XYW-1:0]       xv_reg, xv_next;
    logic signed [63:0]          prod_reg, prod_next;
    logic signed [31:0]          opa, opb;
    logic signed [63:0]          prod_sh;
    logic signed [ZW-1:0]        sh;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [RW-1:0]               ram_wdata, ram_rdata;
    logic                        ram_re;

    thb_pkg::cu_cmd_t            cu_cmd;
    thb_pkg::cu_stat_t           cu_stat;
    logic signed [XYW-1:0]       cu_x0, cu_y0, cu_x, cu_y;
    logic signed [ZW-1:0]        cu_z0, cu_z;

    logic [AW-1:0]               ang;
    logic                        flip;
    logic [AW-1:0]               ang_r;
    logic signed [XYW-1:0]       rx, ry;
    logic [AW-1:0]               zr;

    thb_ram #(.WIDTH(RW), .DEPTH(TEAMS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_lut[team_reg]),
        .rdata (ram_rdata)
    );

    thb_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cu_cmd),
        .x_in    (cu_x0),
        .y_in    (cu_y0),
        .z_in    (cu_z0),
        .stat    (cu_stat),
        .x_out   (cu_x),
        .y_out   (cu_y),
        .z_out   (cu_z)
    );

    always_comb begin
        case (sc_reg)
            2'd0:    ang = ang1_reg;
            2'd1:    ang = lat_reg;
            default: ang = dlon_reg;
        endcase
        ang_r = ang + 32'h4000_0000;
        flip  = ang_r[AW-1];
        case (ms_reg)
            3'd0: begin
                opa = sd_reg;
                opb = c2_reg;
            end
            3'd1: begin
                opa = s1_reg;
                opb = c2_reg;
            end
            3'd2: begin
                opa = c1_reg;
                opb = s2_reg;
            end
            default: begin
                opa = t_reg;
                opb = cd_reg;
            end
        endcase
        prod_sh = prod_reg >>> 30;
        sh      = prod_sh[ZW-1:0];
        rx      = flip_reg ? -cu_x : cu_x;
        ry      = flip_reg ? -cu_y : cu_y;
        zr      = cu_z[AW-1:0] + 32'h0000_8000;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        team_next  = team_reg;
        lat_next   = lat_reg;
        lon_next   = lon_reg;
        yawv_next  = yawv_reg;
        yaw_next   = yaw_reg;
        head_next  = head_reg;
        src_next   = src_reg;
        ang1_next  = ang1_reg;
        dlon_next  = dlon_reg;
        sc_next    = sc_reg;
        flip_next  = flip_reg;
        ms_next    = ms_reg;
        s1_next    = s1_reg;
        c1_next    = c1_reg;
        s2_next    = s2_reg;
        c2_next    = c2_reg;
        sd_next    = sd_reg;
        cd_next    = cd_reg;
        t_next     = t_reg;
        y_next     = y_reg;
        p_next     = p_reg;
        xv_next    = xv_reg;
        prod_next  = opa * opb;
        ram_we     = 1'b0;
        ram_waddr  = idx_lut[team_reg];
        ram_wdata  = {1'b1, lat_reg, lon_reg};
        ram_re     = 1'b0;
        cu_cmd     = '0;
        cu_x0      = thb_pkg::CORDIC_GAIN;
        cu_y0      = '0;
        cu_z0      = ZW'($signed(ang - (flip ? 32'h8000_0000 : 32'h0)));
        case (state_reg)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(TEAMS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    team_next = s_axis_tdata[5:0];
                    lat_next  = s_axis_tdata[37:6];
                    lon_next  = s_axis_tdata[69:38];
                    yaw_next  = s_axis_tdata[85:70];
                    yawv_next = s_axis_tuser[1];
                    if (s_axis_tuser[0]) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                ram_we    = 1'b1;
                ang1_next = ram_rdata[RW-2:AW];
                dlon_next = lon_reg - ram_rdata[AW-1:0];
                sc_next   = 2'd0;
                if (yawv_reg) begin
                    head_next  = yaw_reg;
                    src_next   = thb_pkg::SRC_REPORTED;
                    state_next = ST_OUT;
                end else if (!ram_rdata[RW-1]) begin
                    head_next  = '0;
                    src_next   = thb_pkg::SRC_NEW_TEAM;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                cu_cmd.start = 1'b1;
                flip_next    = flip;
                state_next   = ST_ROTW;
            end
            ST_ROTW: begin
                if (cu_stat.done) begin
                    case (sc_reg)
                        2'd0: begin
                            s1_next = ry[31:0];
                            c1_next = rx[31:0];
                        end
                        2'd1: begin
                            s2_next = ry[31:0];
                            c2_next = rx[31:0];
                        end
                        default: begin
                            sd_next = ry[31:0];
                            cd_next = rx[31:0];
                        end
                    endcase
                    if (sc_reg == 2'd2) begin
                        ms_next    = 3'd0;
                        state_next = ST_MUL;
                    end else begin
                        sc_next    = sc_reg + 2'd1;
                        state_next = ST_ROT;
                    end
                end
            end
            ST_MUL: begin
                ms_next = ms_reg + 3'd1;
                case (ms_reg)
                    3'd1:    y_next = sh;
                    3'd2:    t_next = sh[31:0];
                    3'd3:    p_next = sh;
                    3'd4: begin
                        xv_next    = XYW'(p_reg) - XYW'(sh);
                        state_next = ST_VEC;
                    end
                    default: ;
                endcase
            end
            ST_VEC: begin
                if (xv_reg == '0 && y_reg == '0) begin
                    head_next  = '0;
                    src_next   = thb_pkg::SRC_BEARING;
                    state_next = ST_OUT;
                end else begin
                    cu_cmd.start  = 1'b1;
                    cu_cmd.vector = 1'b1;
                    if (xv_reg < 0) begin
                        cu_x0 = -xv_reg;
                        cu_y0 = -XYW'(y_reg);
                        cu_z0 = ZW'(33'h0_8000_0000);
                    end else begin
                        cu_x0 = xv_reg;
                        cu_y0 = XYW'(y_reg);
                        cu_z0 = '0;
                    end
                    state_next = ST_VECW;
                end
            end
            ST_VECW: begin
                if (cu_stat.done) begin
                    head_next  = zr[31:16];
                    src_next   = thb_pkg::SRC_BEARING;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        team_reg <= team_next;
        lat_reg  <= lat_next;
        lon_reg  <= lon_next;
        yawv_reg <= yawv_next;
        yaw_reg  <= yaw_next;
        head_reg <= head_next;
        src_reg  <= src_next;
        ang1_reg <= ang1_next;
        dlon_reg <= dlon_next;
        sc_reg   <= sc_next;
        flip_reg <= flip_next;
        ms_reg   <= ms_next;
        s1_reg   <= s1_next;
        c1_reg   <= c1_next;
        s2_reg   <= s2_next;
        c2_reg   <= c2_next;
        sd_reg   <= sd_next;
        cd_reg   <= cd_next;
        t_reg    <= t_next;
        y_reg    <= y_next;
        p_reg    <= p_next;
        xv_reg   <= xv_next;
        prod_reg <= prod_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {2'b00, head_reg, lon_reg, lat_reg, team_reg};
    assign m_axis_tuser  = src_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");

    a_src_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == thb_pkg::SRC_REPORTED ||
                           m_axis_tuser == thb_pkg::SRC_BEARING ||
                           m_axis_tuser == thb_pkg::SRC_NEW_TEAM))
        else $error("heading source code out of range");

    a_cordic_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        cu_stat.busy |-> (state_reg == ST_ROTW || state_reg == ST_VECW))
        else $error("CORDIC unit busy outside a wait state");

    a_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == thb_pkg::SRC_REPORTED) |->
        (yawv_reg && head_reg == yaw_reg))
        else $error("reported heading not passed through");
endmodule

>>> src/thb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; no package dependencies.
module thb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> src/thb_cordic.sv
// Iterative CORDIC unit shared by rotation (sine, cosine) and vectoring (atan2).
// One micro-rotation per cycle; uses thb_pkg for widths, commands and the arctangent table.
module thb_cordic #(
    parameter int ITERATIONS = thb_pkg::ITER_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  thb_pkg::cu_cmd_t                 cmd,
    input  logic signed [thb_pkg::XY_W-1:0]  x_in,
    input  logic signed [thb_pkg::XY_W-1:0]  y_in,
    input  logic signed [thb_pkg::Z_W-1:0]   z_in,
    output thb_pkg::cu_stat_t                stat,
    output logic signed [thb_pkg::XY_W-1:0]  x_out,
    output logic signed [thb_pkg::XY_W-1:0]  y_out,
    output logic signed [thb_pkg::Z_W-1:0]   z_out
);
    localparam int CW = $clog2(ITERATIONS);

    logic signed [thb_pkg::XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [thb_pkg::Z_W-1:0]  z_reg, z_next;
    logic [CW-1:0]                   i_reg, i_next;
    logic                            busy_reg, busy_next, done_reg, done_next;
    logic                            vector_reg, vector_next;
    logic signed [thb_pkg::XY_W-1:0] dx, dy;
    logic signed [thb_pkg::Z_W-1:0]  da;
    logic                            ccw;

    always_comb begin
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        da  = thb_pkg::Z_W'(thb_pkg::ATAN_TABLE[5'(i_reg)]);
        ccw = vector_reg ? y_reg[thb_pkg::XY_W-1] : !z_reg[thb_pkg::Z_W-1];
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        i_next      = i_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        vector_next = vector_reg;
        if (cmd.start) begin
            x_next      = x_in;
            y_next      = y_in;
            z_next      = z_in;
            i_next      = '0;
            busy_next   = 1'b1;
            vector_next = cmd.vector;
        end else if (busy_reg) begin
            if (ccw) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            i_next = i_reg + CW'(1);
            if (i_reg == CW'(ITERATIONS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        i_reg      <= i_next;
        vector_reg <= vector_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
endmodule

>>> tb/track_heading_with_bearing_fallback_tb.sv
`timescale 1ns / 100ps
// Testbench for the track heading block: drives position reports and checks every result
// against a bearing predictor built on its own CORDIC sine, cosine and atan2.
// Depends on thb_pkg and the track_heading_with_bearing_fallback top level.
module track_heading_with_bearing_fallback_tb;

    localparam int TEAM_COUNT = 64;
    localparam int ITERS      = 16;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [5:0]  team;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [15:0] heading;
        logic [1:0]  source;
    } heading_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    heading_result_t expected_headings[$];
    bit          team_seen[TEAM_COUNT];
    logic [31:0] team_lat[TEAM_COUNT];
    logic [31:0] team_lon[TEAM_COUNT];
    int          mismatches;
    int          results_seen;
    int          bearings_seen;
    longint      cycles;
    bit          idle_enable;

    track_heading_with_bearing_fallback DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_sin_cos(logic [31:0] angle, output longint s,
                                           output longint c);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, dx, dy;
        flip = ((angle + 32'h4000_0000) & 32'h8000_0000) != 0;
        a = flip ? angle - 32'h8000_0000 : angle;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(thb_pkg::ATAN_TABLE[i]);
            end else begin
                x += dx; y -= dy; z += longint'(thb_pkg::ATAN_TABLE[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [31:0] cordic_atan2(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 64'h8000_0000;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(thb_pkg::ATAN_TABLE[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(thb_pkg::ATAN_TABLE[i]);
            end
        end
        return z[31:0];
    endfunction

    function automatic logic [15:0] initial_bearing(logic [31:0] lat1, logic [31:0] lon1,
                                                    logic [31:0] lat2, logic [31:0] lon2);
        longint      s1, c1, s2, c2, sd, cd, y, x, t;
        logic [31:0] z;
        cordic_sin_cos(lat1, s1, c1);
        cordic_sin_cos(lat2, s2, c2);
        cordic_sin_cos(lon2 - lon1, sd, cd);
        y = floor_shift(sd * c2, 30);
        t = floor_shift(s1 * c2, 30);
        x = floor_shift(c1 * s2, 30) - floor_shift(t * cd, 30);
        if (x == 0 && y == 0) return 16'd0;
        z = cordic_atan2(y, x);
        return 16'((z + 32'h8000) >> 16);
    endfunction

    task automatic predict_heading(logic [5:0] team, bit pos_ok, logic [31:0] lat,
                                   logic [31:0] lon, bit yaw_ok, logic [15:0] yaw);
        heading_result_t r;
        if (!pos_ok) return;
        r.team = team;
        r.lat = lat;
        r.lon = lon;
        if (yaw_ok) begin
            r.heading = yaw; r.source = thb_pkg::SRC_REPORTED;
        end else if (team_seen[team]) begin
            r.heading = initial_bearing(team_lat[team], team_lon[team], lat, lon);
            r.source = thb_pkg::SRC_BEARING;
        end else begin
            r.heading = 16'd0; r.source = thb_pkg::SRC_NEW_TEAM;
        end
        team_seen[team] = 1;
        team_lat[team] = lat;
        team_lon[team] = lon;
        expected_headings.push_back(r);
    endtask

    function automatic bit idle_now();
        return idle_enable && ($urandom_range(99) < 34);
    endfunction

    task automatic send_report(logic [5:0] team, bit pos_ok, logic [31:0] lat,
                               logic [31:0] lon, bit yaw_ok, logic [15:0] yaw);
        while (idle_now()) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, yaw, lon, lat, team};
        s_axis_tuser <= {yaw_ok, pos_ok};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_heading(team, pos_ok, lat, lon, yaw_ok, yaw);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    initial begin
        m_axis_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                heading_result_t r;
                results_seen++;
                if (expected_headings.size() == 0) begin
                    report_mismatch("unexpected item", 32'(m_axis_tdata[5:0]), 0);
                end else begin
                    r = expected_headings.pop_front();
                    if (r.source == thb_pkg::SRC_BEARING) bearings_seen++;
                    if (m_axis_tdata[5:0] != r.team)
                        report_mismatch("team", 32'(m_axis_tdata[5:0]), 32'(r.team));
                    if (m_axis_tdata[37:6] != r.lat)
                        report_mismatch("latitude", m_axis_tdata[37:6], r.lat);
                    if (m_axis_tdata[69:38] != r.lon)
                        report_mismatch("longitude", m_axis_tdata[69:38], r.lon);
                    if (m_axis_tdata[85:70] != r.heading)
                        report_mismatch("heading", 32'(m_axis_tdata[85:70]), 32'(r.heading));
                    if (m_axis_tuser != r.source)
                        report_mismatch("source", 32'(m_axis_tuser), 32'(r.source));
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_lat();
        return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    task automatic test_directed();
        send_report(6'd0, 1, 32'h4000_0000, 32'h8000_0000, 0, 16'h0000);
        send_report(6'd0, 1, 32'hC000_0000, 32'h7FFF_FFFF, 0, 16'h0000);
        send_report(6'd0, 1, 32'hC000_0000, 32'h7FFF_FFFF, 0, 16'h0000);
        send_report(6'd63, 1, 32'h0, 32'h0, 1, 16'hFFFF);
        send_report(6'd63, 1, 32'h0, 32'h0, 1, 16'h0000);
        send_report(6'd63, 1, 32'h0100_0000, 32'h0, 0, 16'h1234);
        send_report(6'd63, 1, 32'h0100_0000, 32'h0100_0000, 0, 16'h0);
        send_report(6'd63, 1, 32'h0, 32'h0100_0000, 0, 16'h0);
        send_report(6'd63, 1, 32'h0, 32'hFFFF_FFFF, 0, 16'h0);
        send_report(6'd5, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'hFFFF);
        send_report(6'd5, 1, 32'h1000_0000, 32'h8000_0000, 0, 16'h0);
        send_report(6'd5, 1, 32'h4000_0000, 32'h0, 0, 16'h0);
        send_report(6'd5, 1, 32'hC000_0000, 32'h8000_0000, 0, 16'h0);
        send_report(6'd5, 1, 32'hC000_0000, 32'h0, 0, 16'h0);
        send_report(6'd5, 0, 32'h0, 32'h0, 0, 16'h0);
        send_report(6'd42, 1, 32'h2000_0000, 32'h4000_0000, 1, 16'hA5A5);
        send_report(6'd42, 1, 32'h2000_0000, 32'hC000_0000, 0, 16'h0);
    endtask

    task automatic test_random(int count);
        logic [5:0] team;
        int         kind;
        logic [31:0] lat, lon;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) idle_enable = 0;
            if (n == count / 2) idle_enable = 1;
            team = (n < count / 2) ? 6'($urandom_range(7)) : 6'($urandom);
            kind = $urandom_range(99);
            lat = rand_lat();
            lon = $urandom;
            if (kind < 10 && team_seen[team]) begin
                lat = team_lat[team] + 32'($urandom_range(4096)) - 32'd2048;
                lon = team_lon[team] + 32'($urandom_range(4096)) - 32'd2048;
            end else if (kind < 14) begin
                lat = $urandom;
            end
            send_report(team, $urandom_range(99) >= 8, lat, lon,
                        $urandom_range(99) < 25, 16'($urandom));
        end
    endtask

    initial begin
        mismatches = 0;
        results_seen = 0;
        bearings_seen = 0;
        idle_enable = 1;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        test_directed();
        test_random(950);
        s_axis_tvalid <= 0;
        while (expected_headings.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Checked %0d results, %0d of them computed bearings.",
                 results_seen, bearings_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
